### src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### src/ihlc_pkg.sv
// Types and constants of the ICAP header line classifier.
`default_nettype none
package ihlc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_last;
  } in_item_t;

  typedef struct packed {
    logic       line_done;
    logic [1:0] line_kind;
    logic [2:0] message_type;
    logic       in_data;
    logic       packet_done;
  } out_item_t;

  // Line kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_BLANK  = 2'd1;
  localparam logic [1:0] KIND_FIELD  = 2'd2;
  localparam logic [1:0] KIND_NOTHDR = 2'd3;

  // Message types
  localparam logic [2:0] MT_OPTIONS  = 3'd0;
  localparam logic [2:0] MT_REQMOD   = 3'd1;
  localparam logic [2:0] MT_RESPMOD  = 3'd2;
  localparam logic [2:0] MT_RESPONSE = 3'd3;
  localparam logic [2:0] MT_OTHER    = 3'd4;

  localparam int unsigned KW_COUNT = 4;
  localparam logic [3:0]  POS_MAX  = 4'd8;

  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_COLON = 8'h3A;

  // Keyword text, unused tail positions are never compared.
  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"I", "C", "A", "P", "/", 8'h00, 8'h00, 8'h00},
    '{"R", "E", "Q", "M", "O", "D", " ", 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S", " "},
    '{"R", "E", "S", "P", "M", "O", "D", " "}
  };
  localparam logic [3:0] KW_LEN  [KW_COUNT] = '{4'd5, 4'd7, 4'd8, 4'd8};
  localparam logic [2:0] KW_TYPE [KW_COUNT] = '{MT_RESPONSE, MT_REQMOD, MT_OPTIONS, MT_RESPMOD};

endpackage
`default_nettype wire

### src/icap_if.sv
// Valid/ready channel interfaces for input bytes and classification results.
`default_nettype none
interface icap_in_if;
  logic               valid;
  logic               ready;
  ihlc_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
  modport mon    (input valid, input ready, input payload);
endinterface

interface icap_out_if;
  logic                valid;
  logic                ready;
  ihlc_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
  modport mon    (input valid, input ready, input payload);
endinterface
`default_nettype wire

### src/icap_header_line_classifier.sv
// ICAP header line classifier: per-byte line split, classification, type latch.
// Each accepted input byte has its result registered into the output register.
// Throughput: one byte per cycle; input ready follows the output register (free or taken).
// The line state and the result are both updated at the input transaction edge.
// Synchronous active-low reset clears all line and packet state; so does the last byte.
`default_nettype none
module icap_header_line_classifier (
  input  wire logic     clk,
  input  wire logic     rst_n,
  icap_in_if.sink       in_ch,
  icap_out_if.source    out_ch
);

  localparam logic [1:0] FS_UNDEC = 2'd0;
  localparam logic [1:0] FS_COLON = 2'd1;
  localparam logic [1:0] FS_REJ   = 2'd2;

  logic       data_mode_r, data_mode_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [3:0] alive_r, alive_nxt;
  logic [1:0] field_r, field_nxt;
  logic [2:0] ltype_r, ltype_nxt;
  logic       cr_seen_r, cr_seen_nxt;

  logic                out_valid_r;
  ihlc_pkg::out_item_t out_item_r, out_item_nxt;

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic       is_term, is_sep, swallow;

  logic [3:0] upd_alive, fin_alive;
  logic [3:0] upd_pos, fin_pos;
  logic [1:0] upd_field, fin_field;
  logic [3:0] match;
  logic [2:0] hit_type;
  logic       finish;
  logic [1:0] kind;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.payload.data_byte;
  assign last        = in_ch.payload.packet_last;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  assign is_term = (b == ihlc_pkg::CHR_CR) || (b == ihlc_pkg::CHR_LF);
  assign swallow = cr_seen_r && (b == ihlc_pkg::CHR_LF);

  always_comb begin
    case (b) inside
      "(", ")", "<", ">", "@", ",", ";", "\\",
      "\"", "/", "[", "]", "?", "=", "{", "}": is_sep = 1'b1;
      default:                                  is_sep = 1'b0;
    endcase
  end

  // Content byte update
  always_comb begin
    upd_alive = alive_r;
    for (int k = 0; k < ihlc_pkg::KW_COUNT; k++) begin
      if (pos_r < ihlc_pkg::KW_LEN[k] && ihlc_pkg::KW_TEXT[k][pos_r[2:0]] != b)
        upd_alive[k] = 1'b0;
    end
    upd_field = field_r;
    if (field_r == FS_UNDEC) begin
      if (b < 8'h20 || b > 8'h7E)       upd_field = FS_REJ;
      else if (b == ihlc_pkg::CHR_COLON) upd_field = FS_COLON;
      else if (is_sep)                   upd_field = FS_REJ;
    end
    upd_pos = (pos_r < ihlc_pkg::POS_MAX) ? pos_r + 4'd1 : pos_r;
  end

  // Terminators classify the line as it stands; a last content byte is included.
  assign fin_alive = is_term ? alive_r : upd_alive;
  assign fin_pos   = is_term ? pos_r   : upd_pos;
  assign fin_field = is_term ? field_r : upd_field;
  assign finish    = !swallow && !data_mode_r && (is_term || last);

  always_comb begin
    for (int k = 0; k < ihlc_pkg::KW_COUNT; k++)
      match[k] = fin_alive[k] && (fin_pos >= ihlc_pkg::KW_LEN[k]);
    hit_type = ihlc_pkg::MT_OTHER;
    for (int k = ihlc_pkg::KW_COUNT - 1; k >= 0; k--)
      if (match[k]) hit_type = ihlc_pkg::KW_TYPE[k];
    if (|match)                 kind = ihlc_pkg::KIND_START;
    else if (fin_pos == 4'd0)   kind = ihlc_pkg::KIND_BLANK;
    else if (fin_field == FS_COLON) kind = ihlc_pkg::KIND_FIELD;
    else                        kind = ihlc_pkg::KIND_NOTHDR;
  end

  always_comb begin
    data_mode_nxt = data_mode_r;
    pos_nxt       = pos_r;
    alive_nxt     = alive_r;
    field_nxt     = field_r;
    ltype_nxt     = ltype_r;
    cr_seen_nxt   = 1'b0;

    out_item_nxt              = '0;
    out_item_nxt.packet_done  = last;
    out_item_nxt.in_data      = !swallow && data_mode_r;

    if (!swallow && !data_mode_r) begin
      if (!is_term) begin
        pos_nxt   = upd_pos;
        alive_nxt = upd_alive;
        field_nxt = upd_field;
      end
      if (b == ihlc_pkg::CHR_CR) cr_seen_nxt = 1'b1;
    end

    if (finish) begin
      out_item_nxt.line_done = 1'b1;
      out_item_nxt.line_kind = kind;
      if (|match && ltype_r == ihlc_pkg::MT_OTHER) ltype_nxt = hit_type;
      if (kind == ihlc_pkg::KIND_NOTHDR) data_mode_nxt = 1'b1;
      pos_nxt   = 4'd0;
      alive_nxt = 4'hF;
      field_nxt = FS_UNDEC;
    end

    out_item_nxt.message_type = ltype_nxt;

    if (last) begin
      data_mode_nxt = 1'b0;
      pos_nxt       = 4'd0;
      alive_nxt     = 4'hF;
      field_nxt     = FS_UNDEC;
      ltype_nxt     = ihlc_pkg::MT_OTHER;
      cr_seen_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_mode_r <= 1'b0;
      pos_r       <= 4'd0;
      alive_r     <= 4'hF;
      field_r     <= FS_UNDEC;
      ltype_r     <= ihlc_pkg::MT_OTHER;
      cr_seen_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        data_mode_r <= data_mode_nxt;
        pos_r       <= pos_nxt;
        alive_r     <= alive_nxt;
        field_r     <= field_nxt;
        ltype_r     <= ltype_nxt;
        cr_seen_r   <= cr_seen_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

### src/ihlc_checker.sv
// Port-level checker for the ICAP header line classifier, with its bind.
`default_nettype none
`include "assert_macros.svh"
module ihlc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire ihlc_pkg::out_item_t out_payload
);

  logic stall;
  logic idle_line;
  logic data_out;

  assign stall     = out_valid && !out_ready;
  assign idle_line = out_valid && !out_payload.line_done;
  assign data_out  = out_valid && out_payload.in_data;

  // A stalled result keeps its transaction.
  `ASSERT_CLK(a_out_hold, stall |=> out_valid && $stable(out_payload), "stalled result changed")
  // Line kind is zero unless a line ends.
  `ASSERT_IMPL(a_kind_idle, idle_line, out_payload.line_kind == ihlc_pkg::KIND_START, "stray kind")
  // Data bytes never end a line.
  `ASSERT_IMPL(a_data_no_line, data_out, !out_payload.line_done, "data byte ended a line")
  // Message type stays in its code range.
  `ASSERT_IMPL(a_type_range, out_valid, out_payload.message_type <= ihlc_pkg::MT_OTHER, "bad type")
  // An empty output register never blocks the input.
  `ASSERT_IMPL(a_in_ready, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind icap_header_line_classifier ihlc_checker u_ihlc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the ICAP header line classifier, with random stimulus.
`default_nettype none
module testbench;

  localparam int          STALL_LIMIT = 2000;
  localparam int          GAP_PCT     = 27;
  localparam logic [3:0]  LINE_CAP    = 4'd8;

  typedef enum logic [1:0] {FIELD_OPEN, FIELD_COLON, FIELD_REJECT} field_state_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   errors;
  int   bytes_sent;

  logic [7:0]          pkt_bytes [$];
  ihlc_pkg::out_item_t expected_results [$];

  // Shadow of the classifier state
  logic         body_mode;
  logic [3:0]   line_len;
  logic [3:0]   kw_alive;
  field_state_t field_state;
  logic [2:0]   msg_type;
  logic         cr_pending;

  icap_in_if  in_ch ();
  icap_out_if out_ch ();

  icap_header_line_classifier u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= GAP_PCT);
  end

  function automatic string keyword_text(input int k);
    case (k)
      0:       return "ICAP/";
      1:       return "REQMOD ";
      2:       return "OPTIONS ";
      default: return "RESPMOD ";
    endcase
  endfunction

  function automatic logic [2:0] keyword_type(input int k);
    case (k)
      0:       return ihlc_pkg::MT_RESPONSE;
      1:       return ihlc_pkg::MT_REQMOD;
      2:       return ihlc_pkg::MT_OPTIONS;
      default: return ihlc_pkg::MT_RESPMOD;
    endcase
  endfunction

  function automatic logic is_separator(input logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", "\\",
      "\"", "/", "[", "]", "?", "=", "{", "}": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void clear_state();
    body_mode   = 1'b0;
    line_len    = '0;
    kw_alive    = 4'hF;
    field_state = FIELD_OPEN;
    msg_type    = ihlc_pkg::MT_OTHER;
    cr_pending  = 1'b0;
  endfunction

  function automatic void take_content(input logic [7:0] b);
    string w;
    for (int k = 0; k < 4; k++) begin
      w = keyword_text(k);
      if (int'(line_len) < w.len() && w[line_len] != b) kw_alive[k] = 1'b0;
    end
    if (field_state == FIELD_OPEN) begin
      if (b < 8'h20 || b > 8'h7E) field_state = FIELD_REJECT;
      else if (b == ihlc_pkg::CHR_COLON) field_state = FIELD_COLON;
      else if (is_separator(b)) field_state = FIELD_REJECT;
    end
    if (line_len < LINE_CAP) line_len = line_len + 4'd1;
  endfunction

  function automatic logic [1:0] close_line();
    logic [1:0] kind;
    logic       matched;
    string      w;
    kind    = ihlc_pkg::KIND_NOTHDR;
    matched = 1'b0;
    // first surviving keyword wins; only the first start line of a packet sets the type
    for (int k = 0; k < 4; k++) begin
      w = keyword_text(k);
      if (!matched && kw_alive[k] && int'(line_len) >= w.len()) begin
        matched = 1'b1;
        if (msg_type == ihlc_pkg::MT_OTHER) msg_type = keyword_type(k);
      end
    end
    if (matched) kind = ihlc_pkg::KIND_START;
    else if (line_len == 0) kind = ihlc_pkg::KIND_BLANK;
    else if (field_state == FIELD_COLON) kind = ihlc_pkg::KIND_FIELD;
    if (kind == ihlc_pkg::KIND_NOTHDR) body_mode = 1'b1;
    line_len    = '0;
    kw_alive    = 4'hF;
    field_state = FIELD_OPEN;
    return kind;
  endfunction

  function automatic ihlc_pkg::out_item_t classify_byte(input ihlc_pkg::in_item_t it);
    ihlc_pkg::out_item_t r;
    logic [7:0]          b;
    r = '0;
    b = it.data_byte;
    if (cr_pending && b == ihlc_pkg::CHR_LF) begin
      // LF of a CR LF pair: swallowed
      cr_pending = 1'b0;
    end else begin
      cr_pending = 1'b0;
      if (body_mode) begin
        r.in_data = 1'b1;
      end else if (b == ihlc_pkg::CHR_CR || b == ihlc_pkg::CHR_LF) begin
        r.line_done = 1'b1;
        r.line_kind = close_line();
        if (b == ihlc_pkg::CHR_CR) cr_pending = 1'b1;
      end else begin
        take_content(b);
        if (it.packet_last) begin
          r.line_done = 1'b1;
          r.line_kind = close_line();
        end
      end
    end
    r.message_type = msg_type;
    r.packet_done  = it.packet_last;
    if (it.packet_last) clear_state();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    $display("mismatch %0d at %0t: %s got %0h expected %0h", errors, $realtime, what,
             got, want);
  endtask

  always @(negedge clk) begin : check_results
    ihlc_pkg::out_item_t got;
    ihlc_pkg::out_item_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.payload;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", 8'(got), 8'h00);
      end else begin
        want = expected_results.pop_front();
        if (got.line_done !== want.line_done)
          report_mismatch("line_done", 8'(got.line_done), 8'(want.line_done));
        if (got.line_kind !== want.line_kind)
          report_mismatch("line_kind", 8'(got.line_kind), 8'(want.line_kind));
        if (got.message_type !== want.message_type)
          report_mismatch("message_type", 8'(got.message_type), 8'(want.message_type));
        if (got.in_data !== want.in_data)
          report_mismatch("in_data", 8'(got.in_data), 8'(want.in_data));
        if (got.packet_done !== want.packet_done)
          report_mismatch("packet_done", 8'(got.packet_done), 8'(want.packet_done));
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(negedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("testbench failed");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the byte was taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    ihlc_pkg::in_item_t it;
    logic               taken;
    it.data_byte   = b;
    it.packet_last = last;
    if (!steady) begin
      while ($urandom_range(99) < GAP_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (in_ch.ready === 1'b1) begin
        taken = 1'b1;
        expected_results.push_back(classify_byte(it));
        bytes_sent++;
      end
      @(posedge clk);
    end
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endtask

  task automatic add_random(input int n, input int lo, input int hi);
    for (int i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom_range(hi, lo)));
  endtask

  task automatic add_eol();
    case ($urandom_range(2))
      0: pkt_bytes.push_back(ihlc_pkg::CHR_CR);
      1: pkt_bytes.push_back(ihlc_pkg::CHR_LF);
      default: begin
        pkt_bytes.push_back(ihlc_pkg::CHR_CR);
        pkt_bytes.push_back(ihlc_pkg::CHR_LF);
      end
    endcase
  endtask

  task automatic add_keyword_line();
    string w;
    int    k;
    k = $urandom_range(3);
    w = keyword_text(k);
    case ($urandom_range(9))
      0: add_text(w.substr(0, $urandom_range(w.len() - 2)));  // cut short
      1: begin
        add_text(w);
        pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom_range(255));
      end
      default: add_text(w);
    endcase
    add_random($urandom_range(12), 8'h20, 8'h7E);
    add_eol();
  endtask

  // Start line, header fields, usually a blank line, body; sometimes cut off early.
  task automatic build_message();
    int keep;
    add_keyword_line();
    repeat ($urandom_range(4)) begin
      case ($urandom_range(7))
        0: add_keyword_line();
        1: begin
          add_random($urandom_range(1, 6), 8'h41, 8'h5A);
          add_text($urandom_range(1) ? "/" : "\"");
          add_text(":");
          add_random($urandom_range(6), 8'h20, 8'h7E);
          add_eol();
        end
        2: begin
          add_random($urandom_range(4), 8'h41, 8'h5A);
          pkt_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h1F)) :
                              8'($urandom_range(8'hFF, 8'h7F)));
          add_text(":");
          add_eol();
        end
        default: begin
          add_random($urandom_range(1, 10), 8'h41, 8'h7A);
          add_text(": ");
          add_random($urandom_range(12), 8'h20, 8'h7E);
          add_eol();
        end
      endcase
    end
    if ($urandom_range(99) < 85) add_eol();
    add_random($urandom_range(12), 0, 255);
    if ($urandom_range(99) < 15) begin
      keep = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic build_noise();
    repeat ($urandom_range(1, 24)) begin
      case ($urandom_range(7))
        0: pkt_bytes.push_back(ihlc_pkg::CHR_CR);
        1: pkt_bytes.push_back(ihlc_pkg::CHR_LF);
        2: pkt_bytes.push_back(ihlc_pkg::CHR_COLON);
        3: add_text($urandom_range(1) ? "/" : " ");
        default: pkt_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic test_directed();
    // keyword line ended by lone CR, field, CR LF, blank line, short trailing line
    add_text("REQMOD ");
    pkt_bytes.push_back(ihlc_pkg::CHR_CR);
    add_text("A:");
    pkt_bytes.push_back(ihlc_pkg::CHR_CR);
    pkt_bytes.push_back(ihlc_pkg::CHR_LF);
    pkt_bytes.push_back(ihlc_pkg::CHR_CR);
    pkt_bytes.push_back(ihlc_pkg::CHR_LF);
    add_text("x");
    send_packet();
    // separator ends the header section, extreme bytes land in data
    add_text("a/");
    pkt_bytes.push_back(ihlc_pkg::CHR_LF);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(8'h00);
    send_packet();
    // lone non-printable byte as a whole packet
    pkt_bytes.push_back(8'h7F);
    send_packet();
    // not-header line ended by CR LF at packet end, LF swallowed
    add_text("b");
    pkt_bytes.push_back(ihlc_pkg::CHR_CR);
    pkt_bytes.push_back(ihlc_pkg::CHR_LF);
    send_packet();
  endtask

  task automatic test_steady_stream();
    int start;
    start  = bytes_sent;
    steady = 1'b1;
    while (bytes_sent - start < 300) begin
      build_message();
      send_packet();
    end
    steady = 1'b0;
  endtask

  task automatic test_messages();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 900) begin
      build_message();
      send_packet();
    end
  endtask

  task automatic test_noise();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < 400) begin
      if ($urandom_range(99) < 60) build_noise();
      else build_message();
      send_packet();
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    rst_n         <= 1'b0;
    steady     = 1'b0;
    errors     = 0;
    bytes_sent = 0;
    clear_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_steady_stream();
    test_messages();
    test_noise();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
`default_nettype wire
